### rtl/crb_pkg.sv
package crb_pkg;

   localparam int CAPACITY    = 16;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int WORD_W      = 32;
   localparam int STEP_W      = 16;
   localparam int STEP_CNT_W  = $clog2(STEP_W);
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 2;
   localparam int RING_SIZE_W = 5;

   typedef enum logic [OP_W-1:0] {
      OP_ADD        = 3'd0,
      OP_TAKE       = 3'd1,
      OP_DROP_VALUE = 3'd2,
      OP_ROTATE     = 3'd3,
      OP_REVERSE    = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CA_HOLD,
      CA_WRITE,
      CA_SHIFT,
      CA_DROP,
      CA_ROT_LEFT,
      CA_ROT_RIGHT,
      CA_REVERSE
   } cell_action_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_DIVIDE,
      FSM_ROTATE,
      FSM_REPORT
   } fsm_state_type;

   // broadcast to every cell
   typedef struct packed {
      cell_action_type          action;
      logic [CNT_W-1:0]         count;
      logic signed [WORD_W-1:0] head_word;
      logic signed [WORD_W-1:0] tail_word;
   } cell_ctl_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] remainder;
   } mod_result_type;

endpackage

### rtl/crb_req_if.sv
interface crb_req_if import crb_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          req_type;
   logic signed [WORD_W-1:0] item_value;
   logic signed [STEP_W-1:0] rotate_steps;

   modport source (output valid, output req_type, output item_value, output rotate_steps,
                   input ready);
   modport sink   (input valid, input req_type, input item_value, input rotate_steps,
                   output ready);
endinterface

### rtl/crb_rsp_if.sv
interface crb_rsp_if import crb_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [WORD_W-1:0]  removed_value;
   logic [RING_SIZE_W-1:0]    ring_size;
   logic                      cursor_valid;
   logic signed [WORD_W-1:0]  cursor_value;

   modport source (output valid, output status, output removed_value, output ring_size,
                   output cursor_valid, output cursor_value, input ready);
   modport sink   (input valid, input status, input removed_value, input ring_size,
                   input cursor_valid, input cursor_value, output ready);
endinterface

### rtl/crb_cell.sv
module crb_cell import crb_pkg::*; (
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic [IDX_W-1:0]         cell_index,
   input  logic signed [WORD_W-1:0] key_word,
   input  logic signed [WORD_W-1:0] next_word,
   input  logic signed [WORD_W-1:0] prev_word,
   input  logic signed [WORD_W-1:0] mirror_word,
   input  logic                     hit_before,
   output logic                     hit_out,
   output logic signed [WORD_W-1:0] word
);

   logic signed [WORD_W-1:0] word_ff;
   logic signed [WORD_W-1:0] word_in;
   logic [CNT_W-1:0]         pos;
   logic                     in_use;
   logic                     is_last;

   assign pos     = CNT_W'(cell_index);
   assign in_use  = pos < ctl.count;
   assign is_last = pos == (ctl.count - CNT_W'(1));
   // first match seen at or before this cell
   assign hit_out = hit_before | (in_use && (word_ff == key_word));
   assign word    = word_ff;

   always_comb begin
      word_in = word_ff;
      case (ctl.action)
         CA_WRITE: begin
            if (pos == ctl.count) word_in = key_word;
         end
         CA_SHIFT: begin
            word_in = next_word;
         end
         CA_DROP: begin
            if (hit_out) word_in = next_word;
         end
         CA_ROT_LEFT: begin
            word_in = is_last ? ctl.head_word : next_word;
         end
         CA_ROT_RIGHT: begin
            word_in = (pos == '0) ? ctl.tail_word : prev_word;
         end
         CA_REVERSE: begin
            if (in_use) word_in = mirror_word;
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

### rtl/crb_mod_unit.sv
module crb_mod_unit import crb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [STEP_W-1:0] dividend,
   input  logic [CNT_W-1:0]  divisor,
   output mod_result_type    result
);

   // restoring remainder, one dividend bit per cycle
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     quot_ff, quot_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [STEP_CNT_W-1:0] step_ff, step_in;
   logic [CNT_W:0]        trial;
   logic [CNT_W:0]        trial_diff;

   assign trial      = {rem_ff, quot_ff[STEP_W-1]};
   assign trial_diff = trial - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         quot_in = dividend;
         rem_in  = '0;
         step_in = STEP_CNT_W'(STEP_W - 1);
      end else if (busy_ff) begin
         quot_in = {quot_ff[STEP_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial_diff[CNT_W-1:0];
         end else begin
            rem_in = trial[CNT_W-1:0];
         end
         step_in = step_ff - STEP_CNT_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign result.done      = done_ff;
   assign result.remainder = rem_ff;

endmodule

### rtl/cursor_ring_buffer.sv
// Ring of up to CAPACITY signed words, kept as a row of cells in traversal order from the cursor.
// Add, remove current, remove value and reverse: one cell-row update in the accepting cycle, then
//   the report state loads the response register, waiting while an earlier response is unaccepted.
// Rotate: bit-serial step reduction (mod ring size), then k single-step shifts with k < ring size,
//   then the report state (an empty ring goes straight there); requests are taken only when idle.
// Synchronous reset empties the ring and drops any pending response; cell contents are not reset.
module cursor_ring_buffer import crb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   crb_req_if.sink   req_chan,
   crb_rsp_if.source rsp_chan
);

   // ---------------------------------------------------------------- cell row
   logic signed [WORD_W-1:0] cell_word [CAPACITY];
   logic                     cell_hit  [CAPACITY];
   cell_ctl_type             cell_ctl;
   cell_action_type          cell_action;
   logic [CNT_W-1:0]         tail_pos;

   fsm_state_type            state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;

   assign tail_pos           = count_ff - CNT_W'(1);
   assign cell_ctl.action    = cell_action;
   assign cell_ctl.count     = count_ff;
   assign cell_ctl.head_word = cell_word[0];
   assign cell_ctl.tail_word = cell_word[tail_pos[IDX_W-1:0]];

   generate
      for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [CNT_W-1:0]         mirror_pos;
         logic signed [WORD_W-1:0] next_word;
         logic signed [WORD_W-1:0] prev_word;
         logic                     hit_before;

         // reverse pairs cell i with cell (count-1-i)
         assign mirror_pos = count_ff - CNT_W'(1) - CNT_W'(gi);
         assign next_word  = cell_word[(gi + 1) % CAPACITY];
         assign prev_word  = cell_word[(gi + CAPACITY - 1) % CAPACITY];
         assign hit_before = (gi == 0) ? 1'b0 : cell_hit[(gi + CAPACITY - 1) % CAPACITY];

         crb_cell u_cell (
            .clock       (clock),
            .ctl         (cell_ctl),
            .cell_index  (IDX_W'(gi)),
            .key_word    (req_chan.item_value),
            .next_word   (next_word),
            .prev_word   (prev_word),
            .mirror_word (cell_word[mirror_pos[IDX_W-1:0]]),
            .hit_before  (hit_before),
            .hit_out     (cell_hit[gi]),
            .word        (cell_word[gi])
         );
      end
   endgenerate

   // ------------------------------------------------------ step reduction unit
   mod_result_type    mod_res;
   logic              mod_start;
   logic              steps_neg;
   logic [STEP_W-1:0] steps_mag;

   assign steps_neg = req_chan.rotate_steps[STEP_W-1];
   // magnitude of a 16-bit signed count; the most negative value maps to 32768
   assign steps_mag = steps_neg ? (STEP_W'(0) - STEP_W'(req_chan.rotate_steps))
                                : STEP_W'(req_chan.rotate_steps);

   crb_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (steps_mag),
      .divisor  (count_ff),
      .result   (mod_res)
   );

   // ------------------------------------------------------------ control
   op_type                   op;
   logic                     req_accept;
   logic                     load_rsp;
   status_type               status_ff, status_in;
   logic signed [WORD_W-1:0] removed_ff, removed_in;
   logic                     neg_ff, neg_in;
   logic [CNT_W-1:0]         steps_ff, steps_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff;
   logic signed [WORD_W-1:0]  rsp_removed_ff;
   logic [RING_SIZE_W-1:0]    rsp_size_ff;
   logic                      rsp_cursor_valid_ff;
   logic signed [WORD_W-1:0]  rsp_cursor_ff;

   assign op             = op_type'(req_chan.req_type);
   assign req_chan.ready = (state_ff == FSM_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      removed_in  = removed_ff;
      neg_in      = neg_ff;
      steps_in    = steps_ff;
      cell_action = CA_HOLD;
      mod_start   = 1'b0;
      load_rsp    = 1'b0;

      case (state_ff)
         FSM_IDLE: begin
            if (req_accept) begin
               status_in  = ST_OK;
               removed_in = '0;
               state_in   = FSM_REPORT;
               case (op)
                  OP_ADD: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        cell_action = CA_WRITE;
                        count_in    = count_ff + CNT_W'(1);
                     end
                  end
                  OP_TAKE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        cell_action = CA_SHIFT;
                        removed_in  = cell_word[0];
                        count_in    = count_ff - CNT_W'(1);
                     end
                  end
                  OP_DROP_VALUE: begin
                     // last cell's hit carries "any match in the ring"
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (cell_hit[CAPACITY-1]) begin
                        cell_action = CA_DROP;
                        count_in    = count_ff - CNT_W'(1);
                     end else begin
                        status_in = ST_MISSING;
                     end
                  end
                  OP_ROTATE: begin
                     if (count_ff != '0) begin
                        mod_start = 1'b1;
                        neg_in    = steps_neg;
                        state_in  = FSM_DIVIDE;
                     end
                  end
                  OP_REVERSE: begin
                     cell_action = CA_REVERSE;
                  end
                  default: begin
                     cell_action = CA_HOLD;
                  end
               endcase
            end
         end
         FSM_DIVIDE: begin
            if (mod_res.done) begin
               steps_in = mod_res.remainder;
               state_in = FSM_ROTATE;
            end
         end
         FSM_ROTATE: begin
            // backward rotation by r is done as r single steps to the right
            if (steps_ff == '0) begin
               state_in = FSM_REPORT;
            end else begin
               cell_action = neg_ff ? CA_ROT_RIGHT : CA_ROT_LEFT;
               steps_in    = steps_ff - CNT_W'(1);
            end
         end
         FSM_REPORT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff  <= status_in;
      removed_ff <= removed_in;
      neg_ff     <= neg_in;
      steps_ff   <= steps_in;
      if (load_rsp) begin
         rsp_status_ff       <= status_ff;
         rsp_removed_ff      <= removed_ff;
         rsp_size_ff         <= RING_SIZE_W'(count_ff);
         rsp_cursor_valid_ff <= (count_ff != '0);
         rsp_cursor_ff       <= (count_ff != '0) ? cell_word[0] : '0;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.removed_value = rsp_removed_ff;
   assign rsp_chan.ring_size     = rsp_size_ff;
   assign rsp_chan.cursor_valid  = rsp_cursor_valid_ff;
   assign rsp_chan.cursor_value  = rsp_cursor_ff;

   // ------------------------------------------------------------ assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("ring count above capacity");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != FSM_IDLE)
      else $error("request accepted but control stayed idle");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && op == OP_ADD && count_ff < CNT_W'(CAPACITY))
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("add did not grow the ring");

   a_cursor_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.cursor_valid == (rsp_chan.ring_size != '0)))
      else $error("cursor flag disagrees with ring size");

endmodule

### tb/cursor_ring_buffer_test.sv
`timescale 1ns / 100ps

module cursor_ring_buffer_test import crb_pkg::*; ();

   // codes 5..7 carry no operation; the block must answer them with no change
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

   localparam int RANDOM_REQUESTS  = 1950;
   localparam int QUIET_TAIL       = 200;   // last requests run with no idling at all
   localparam int PHASE_LEN        = 250;
   localparam int LONG_HOLD_CYCLES = 400;   // response side stalls long enough to back up requests
   localparam int DRAIN_CYCLES     = 40;
   localparam int MAX_REPORTED     = 10;

   // what the block reports after one request
   typedef struct packed {
      status_type               status;
      logic signed [WORD_W-1:0] removed;
      logic [RING_SIZE_W-1:0]   size;
      logic                     cur_valid;
      logic signed [WORD_W-1:0] cur_value;
   } ring_report_type;

   // one line of the opening request table
   typedef struct {
      logic [OP_W-1:0]          op;
      logic signed [WORD_W-1:0] value;
      logic signed [STEP_W-1:0] steps;
      int                       reps;
      bit                       typed;   // report written out by hand, else predicted
      ring_report_type          report;
   } ring_request_type;

   localparam ring_report_type PREDICTED = '0;

   logic clock;
   logic reset;

   crb_req_if req_bus ();
   crb_rsp_if rsp_bus ();

   cursor_ring_buffer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // words in traversal order, cursor word at the front
   logic signed [WORD_W-1:0] model_ring [$];
   ring_report_type          awaited_reports [$];
   ring_request_type         opening_requests [$];

   int unsigned failures;
   int          req_gap_pct;
   int          rsp_stall_pct;
   bit          hold_rsp_long;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   // Applies one request to the model ring and returns what the block should report.
   function automatic ring_report_type next_ring_report(input logic [OP_W-1:0] op,
                                                        input logic signed [WORD_W-1:0] value,
                                                        input logic signed [STEP_W-1:0] steps);
      ring_report_type          rpt;
      logic signed [WORD_W-1:0] w;
      int                       n;
      int                       hit;
      int                       k;
      int                       i;
      rpt        = '0;
      rpt.status = ST_OK;
      n          = model_ring.size();
      case (op)
         OP_ADD: begin
            if (n >= CAPACITY) rpt.status = ST_FULL;
            else model_ring.push_back(value);
         end
         OP_TAKE: begin
            if (n == 0) rpt.status = ST_EMPTY;
            else rpt.removed = model_ring.pop_front();
         end
         OP_DROP_VALUE: begin
            if (n == 0) begin
               rpt.status = ST_EMPTY;
            end else begin
               // first match from the cursor onward
               hit = -1;
               for (i = 0; i < n; i++)
                  if (hit < 0 && model_ring[i] == value) hit = i;
               if (hit < 0) rpt.status = ST_MISSING;
               else model_ring.delete(hit);
            end
         end
         OP_ROTATE: begin
            if (n > 0) begin
               // backward moves become the complementary forward move
               if (steps < 0) k = (n - ((-int'(steps)) % n)) % n;
               else k = int'(steps) % n;
               repeat (k) begin
                  w = model_ring.pop_front();
                  model_ring.push_back(w);
               end
            end
         end
         OP_REVERSE: begin
            for (i = 0; i < n / 2; i++) begin
               w                 = model_ring[i];
               model_ring[i]     = model_ring[n-1-i];
               model_ring[n-1-i] = w;
            end
         end
         default: ;   // spare codes: nothing changes
      endcase
      n             = model_ring.size();
      rpt.size      = RING_SIZE_W'(n);
      rpt.cur_valid = (n > 0);
      rpt.cur_value = (n > 0) ? model_ring[0] : '0;
      return rpt;
   endfunction

   task automatic add_row(input logic [OP_W-1:0] op, input logic signed [WORD_W-1:0] value,
                          input logic signed [STEP_W-1:0] steps, input int reps, input bit typed,
                          input ring_report_type report);
      ring_request_type row;
      row.op     = op;
      row.value  = value;
      row.steps  = steps;
      row.reps   = reps;
      row.typed  = typed;
      row.report = report;
      opening_requests.push_back(row);
   endtask

   // Offers one request, holds it until taken, then files its expected report.
   // Entered and left at a rising edge.
   task automatic send_request(input logic [OP_W-1:0] op, input logic signed [WORD_W-1:0] value,
                               input logic signed [STEP_W-1:0] steps, input bit typed,
                               input ring_report_type typed_report);
      ring_report_type predicted;
      if (req_gap_pct != 0 && $urandom_range(1, 100) <= req_gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= op;
      req_bus.item_value   <= value;
      req_bus.rotate_steps <= steps;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      // model always advances so later predictions see the same ring
      predicted = next_ring_report(op, value, steps);
      awaited_reports.push_back(typed ? typed_report : predicted);
   endtask

   // Response pacing: random stall bursts, plus one long hold on request.
   initial begin : rsp_pacing
      int c;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_rsp_long) begin
            hold_rsp_long = 1'b0;
            rsp_bus.ready <= 1'b0;
            for (c = 0; c < LONG_HOLD_CYCLES; c++) @(posedge clock);
         end else if (rsp_stall_pct != 0 && $urandom_range(1, 100) <= rsp_stall_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare every accepted response with the oldest expected report.
   always @(posedge clock) begin : report_check
      ring_report_type seen;
      ring_report_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.status    = status_type'(rsp_bus.status);
         seen.removed   = rsp_bus.removed_value;
         seen.size      = rsp_bus.ring_size;
         seen.cur_valid = rsp_bus.cursor_valid;
         seen.cur_value = rsp_bus.cursor_value;
         if (awaited_reports.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTED)
               $display("%0t: response with no request pending (size %0d)", $realtime,
                        seen.size);
         end else begin
            want = awaited_reports.pop_front();
            if (seen.status !== want.status || seen.removed !== want.removed ||
                seen.size !== want.size || seen.cur_valid !== want.cur_valid ||
                seen.cur_value !== want.cur_value) begin
               failures++;
               if (failures <= MAX_REPORTED) begin
                  $write("%0t: mismatch exp st=%0d rm=%0d sz=%0d cv=%0b cur=%0d", $realtime,
                         want.status, want.removed, want.size, want.cur_valid,
                         want.cur_value);
                  $display(" | got st=%0d rm=%0d sz=%0d cv=%0b cur=%0d", seen.status,
                           seen.removed, seen.size, seen.cur_valid, seen.cur_value);
               end
            end
         end
      end
   end

   initial begin : stimulus
      logic [OP_W-1:0]          op;
      logic signed [WORD_W-1:0] value;
      logic signed [STEP_W-1:0] steps;
      int                       ring_requests;
      int                       fill_mode;
      int                       pick;
      int                       n;
      int                       add_pct, take_pct, drop_pct, rot_pct;

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.req_type     <= '0;
      req_bus.item_value   <= '0;
      req_bus.rotate_steps <= '0;
      failures      = 0;
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      hold_rsp_long = 1'b0;
      fill_mode     = 2;

      // opening table: empty-ring cases, single word, wrap extremes, fill to full
      add_row(OP_TAKE, 0, 0, 1, 1'b1, '{ST_EMPTY, 0, 0, 1'b0, 0});
      add_row(OP_DROP_VALUE, 0, 0, 1, 1'b1, '{ST_EMPTY, 0, 0, 1'b0, 0});
      add_row(OP_ROTATE, 0, 16'sh7FFF, 1, 1'b1, '{ST_OK, 0, 0, 1'b0, 0});
      add_row(OP_REVERSE, 0, 0, 1, 1'b1, '{ST_OK, 0, 0, 1'b0, 0});
      add_row(OP_SPARE_FIRST, -1, -1, 1, 1'b1, '{ST_OK, 0, 0, 1'b0, 0});
      add_row(OP_ADD, 32'sh7FFF_FFFF, 0, 1, 1'b1, '{ST_OK, 0, 1, 1'b1, 32'sh7FFF_FFFF});
      // reverse of a lone word leaves it alone
      add_row(OP_REVERSE, 0, 0, 1, 1'b1, '{ST_OK, 0, 1, 1'b1, 32'sh7FFF_FFFF});
      add_row(OP_ADD, 32'sh8000_0000, 0, 1, 1'b1, '{ST_OK, 0, 2, 1'b1, 32'sh7FFF_FFFF});
      add_row(OP_ROTATE, 0, 16'sh8000, 1, 1'b0, PREDICTED);   // multiple of size
      add_row(OP_DROP_VALUE, 5, 0, 1, 1'b0, PREDICTED);       // no match
      add_row(OP_ADD, -1, 0, 14, 1'b0, PREDICTED);            // fill up
      add_row(OP_ADD, 0, 0, 1, 1'b0, PREDICTED);              // dropped, ring full
      add_row(OP_TAKE, 0, 0, 1, 1'b0, PREDICTED);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      foreach (opening_requests[r])
         repeat (opening_requests[r].reps)
            send_request(opening_requests[r].op, opening_requests[r].value,
                         opening_requests[r].steps, opening_requests[r].typed,
                         opening_requests[r].report);

      // random traffic: fill/drain drift keeps the ring moving between empty and full
      hold_rsp_long = 1'b1;
      ring_requests = 0;
      while (ring_requests < RANDOM_REQUESTS) begin
         if (ring_requests >= RANDOM_REQUESTS - QUIET_TAIL) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end else begin
            case ((ring_requests / PHASE_LEN) % 4)
               0: begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
               1: begin req_gap_pct = 25; rsp_stall_pct = 0;  end
               2: begin req_gap_pct = 0;  rsp_stall_pct = 25; end
               default: begin req_gap_pct = 30; rsp_stall_pct = 30; end
            endcase
         end
         if (ring_requests % 40 == 0) fill_mode = $urandom_range(0, 2);
         case (fill_mode)
            0: begin add_pct = 15; take_pct = 35; drop_pct = 25; rot_pct = 15; end
            1: begin add_pct = 55; take_pct = 10; drop_pct = 10; rot_pct = 15; end
            default: begin add_pct = 30; take_pct = 20; drop_pct = 20; rot_pct = 20; end
         endcase

         n = model_ring.size();
         if ($urandom_range(0, 99) < 2) begin
            op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < add_pct) op = OP_ADD;
            else if (pick < add_pct + take_pct) op = OP_TAKE;
            else if (pick < add_pct + take_pct + drop_pct) op = OP_DROP_VALUE;
            else if (pick < add_pct + take_pct + drop_pct + rot_pct) op = OP_ROTATE;
            else op = OP_REVERSE;
         end

         // small pool makes duplicates, so first-match order matters on remove value
         case ($urandom_range(0, 5))
            0, 1: value = $urandom;
            2: value = WORD_W'(int'($urandom_range(0, 6)) - 3);
            3: value = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: begin
               if (op == OP_DROP_VALUE && n > 0) value = model_ring[$urandom_range(0, n - 1)];
               else value = WORD_W'(int'($urandom_range(0, 6)) - 3);
            end
         endcase

         case ($urandom_range(0, 3))
            0: steps = STEP_W'($urandom);
            1: steps = STEP_W'(int'($urandom_range(0, 40)) - 20);
            2: steps = STEP_W'(((n == 0) ? 1 : n) * (int'($urandom_range(0, 8)) - 4));
            default: steps = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         endcase

         send_request(op, value, steps, 1'b0, PREDICTED);
         if (op <= OP_REVERSE) ring_requests++;
      end

      req_bus.valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0 && awaited_reports.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
rtl/crb_pkg.sv
rtl/crb_req_if.sv
rtl/crb_rsp_if.sv
rtl/crb_cell.sv
rtl/crb_mod_unit.sv
rtl/cursor_ring_buffer.sv
tb/cursor_ring_buffer_test.sv
